// ----- src/bragg_reflector_normal_defines.svh -----
// ----------------------------------------------------------------------------
// Bragg reflector normal: assertion macros
// Shared property forms for the checker. Each use expands to one labeled
// concurrent assertion clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BRAGG_REFLECTOR_NORMAL_DEFINES_SVH
`define BRAGG_REFLECTOR_NORMAL_DEFINES_SVH

// Same-cycle implication.
`define BRN_ASSERT_IMPL(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("brn check failed: same-cycle implication");

// Next-cycle implication.
`define BRN_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("brn check failed: next-cycle implication");

`endif

// ----- src/brn_pkg.sv -----
// ----------------------------------------------------------------------------
// Bragg reflector normal: package
// Field widths, internal datapath widths, register indexes, error codes and
// the structs that travel between the pipeline sections.
// ----------------------------------------------------------------------------
`default_nettype none

package brn_pkg;

  // Port fields.
  localparam int IDX_W      = 7;
  localparam int ENTRY_W    = 21;
  localparam int ROW_W      = 63;
  localparam int QWL_W      = 40;
  localparam int OUT_W      = 16;
  localparam int ERR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  // Datapath widths.
  localparam int PROD_W   = 28;   // entry times index
  localparam int G_W      = 29;   // sum of three products
  localparam int MAG_W    = 28;   // magnitude of one component
  localparam int SQ_W     = 56;   // exact square of a magnitude
  localparam int NSQ_W    = 56;   // squared norm in units of 2^-32
  localparam int SHIFT_W  = 5;
  localparam int NORM_TOP = 30;   // bit that holds the top of the largest component
  localparam int SMAG_W   = 31;   // normalized magnitude
  localparam int SSQ_W    = 62;
  localparam int SSUM_W   = 64;
  localparam int ROOT_W   = 32;

  // Sine squared product, split into four partial products.
  localparam int Q_SPLIT   = 20;
  localparam int N_SPLIT   = 28;
  localparam int PP_W      = Q_SPLIT + N_SPLIT;
  localparam int HALF_W    = PP_W + Q_SPLIT + 1;
  localparam int S2P_W     = QWL_W + NSQ_W + 1;
  localparam int S2_LSB    = 56;
  localparam int S2_ROUND  = 55;

  localparam int OUT_NEG_MAX = 32768;
  localparam int OUT_POS_MAX = 32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2,
    REG_QWL   = 2'd3
  } cfg_reg_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK   = 2'd0,
    ERR_ZERO = 2'd1,
    ERR_SAT  = 2'd2
  } err_t;

  // Per-item flags and the finished sine squared.
  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
    logic             sat;
    logic [OUT_W-1:0] sin_sq;
  } side_t;

  // What rides along with the square root.
  typedef struct packed {
    logic [2:0][SMAG_W-1:0] smag;
    side_t                  side;
  } sqrt_pay_t;

endpackage

`default_nettype wire

// ----- src/brn_front.sv -----
// ----------------------------------------------------------------------------
// Bragg reflector normal: front pipeline
// Eight stages: index clamp, matrix products, component sums and magnitudes,
// squares and leading-one search, normalizing shift and squared norm, then
// the split sine squared product alongside the sum of normalized squares.
// ----------------------------------------------------------------------------
`default_nettype none

module brn_front #(
  parameter int INDEX_LIMIT = 63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic signed [brn_pkg::IDX_W-1:0] in_h,
  input  logic signed [brn_pkg::IDX_W-1:0] in_k,
  input  logic signed [brn_pkg::IDX_W-1:0] in_l,
  input  logic [brn_pkg::ROW_W-1:0]      row_x,
  input  logic [brn_pkg::ROW_W-1:0]      row_y,
  input  logic [brn_pkg::ROW_W-1:0]      row_z,
  input  logic [brn_pkg::QWL_W-1:0]      qwl,
  output logic                           out_valid,
  output logic [brn_pkg::SSUM_W-1:0]     out_ssum,
  output brn_pkg::sqrt_pay_t             out_pay
);
  import brn_pkg::*;

  localparam int LIM_BITS = $clog2(INDEX_LIMIT + 1) + 1;
  localparam int CMP_W    = (LIM_BITS > IDX_W) ? LIM_BITS + 1 : IDX_W + 1;
  localparam logic signed [CMP_W-1:0] LIM_POS = CMP_W'(INDEX_LIMIT);
  localparam logic signed [CMP_W-1:0] LIM_NEG = -LIM_POS;

  logic [7:0] vld;

  logic [IDX_W-1:0]          raw [3];
  logic signed [IDX_W-1:0]   idx_next [3];
  logic [ROW_W-1:0]          rows [3];
  logic signed [IDX_W-1:0]   idx [3];
  logic signed [PROD_W-1:0]  prod_next [9];
  logic signed [PROD_W-1:0]  prod [9];
  logic [MAG_W-1:0]          mag_next [3];
  logic [2:0]                neg_next;
  logic [MAG_W-1:0]          mag3 [3];
  logic [2:0]                neg3;
  logic [MAG_W-1:0]          orr;
  logic [SHIFT_W-1:0]        top;
  logic [SQ_W-1:0]           sq4 [3];
  logic [MAG_W-1:0]          mag4 [3];
  logic [SHIFT_W-1:0]        sh4;
  logic                      zero4;
  logic [2:0]                neg4;
  logic [NSQ_W-1:0]          nsq5;
  logic [2:0][SMAG_W-1:0]    smag5;
  logic                      zero5;
  logic [2:0]                neg5;
  logic [PP_W-1:0]           pp00, pp01, pp10, pp11;
  logic [SSQ_W-1:0]          ssq6 [3];
  logic [2:0][SMAG_W-1:0]    smag6;
  logic                      zero6;
  logic [2:0]                neg6;
  logic [HALF_W-1:0]         lo7, hi7;
  logic [SSUM_W-1:0]         ssum7;
  logic [2:0][SMAG_W-1:0]    smag7;
  logic                      zero7;
  logic [2:0]                neg7;
  logic [S2P_W-1:0]          prod8;
  logic [SSUM_W-1:0]         ssum8;
  logic [2:0][SMAG_W-1:0]    smag8;
  logic                      zero8;
  logic [2:0]                neg8;
  logic                      sat8;

  assign raw[0]  = in_h;
  assign raw[1]  = in_k;
  assign raw[2]  = in_l;
  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  // Stage 1: clamp the indices.
  always_comb begin
    logic signed [CMP_W-1:0] ext;
    for (int j = 0; j < 3; j++) begin
      ext = {{(CMP_W - IDX_W){raw[j][IDX_W-1]}}, raw[j]};
      if (ext > LIM_POS) ext = LIM_POS;
      if (ext < LIM_NEG) ext = LIM_NEG;
      idx_next[j] = IDX_W'(ext);
    end
  end

  // Stage 2: nine entry times index products.
  always_comb begin
    logic signed [ENTRY_W-1:0] e;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e = rows[i][ENTRY_W*j +: ENTRY_W];
        prod_next[3*i+j] = PROD_W'(e) * PROD_W'(idx[j]);
      end
    end
  end

  // Stage 3: component sums, split into sign and magnitude.
  always_comb begin
    logic signed [G_W-1:0] g;
    for (int i = 0; i < 3; i++) begin
      g = G_W'(prod[3*i]) + G_W'(prod[3*i+1]) + G_W'(prod[3*i+2]);
      neg_next[i] = g[G_W-1];
      mag_next[i] = MAG_W'(g[G_W-1] ? -g : g);
    end
  end

  // The top bit of the largest magnitude is the top bit of the OR of all three.
  always_comb begin
    orr = mag3[0] | mag3[1] | mag3[2];
    top = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (orr[b]) top = SHIFT_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) idx[j] <= idx_next[j];
      for (int n = 0; n < 9; n++) prod[n] <= prod_next[n];
      for (int i = 0; i < 3; i++) mag3[i] <= mag_next[i];
      neg3 <= neg_next;

      // Stage 4
      for (int i = 0; i < 3; i++) begin
        sq4[i]  <= SQ_W'(mag3[i]) * SQ_W'(mag3[i]);
        mag4[i] <= mag3[i];
      end
      sh4   <= SHIFT_W'(NORM_TOP) - top;
      zero4 <= (orr == '0);
      neg4  <= neg3;

      // Stage 5
      nsq5 <= NSQ_W'(sq4[0] >> 2) + NSQ_W'(sq4[1] >> 2) + NSQ_W'(sq4[2] >> 2);
      for (int i = 0; i < 3; i++) smag5[i] <= SMAG_W'(mag4[i]) << sh4;
      zero5 <= zero4;
      neg5  <= neg4;

      // Stage 6
      pp00 <= PP_W'(qwl[Q_SPLIT-1:0]) * PP_W'(nsq5[N_SPLIT-1:0]);
      pp01 <= PP_W'(qwl[Q_SPLIT-1:0]) * PP_W'(nsq5[NSQ_W-1:N_SPLIT]);
      pp10 <= PP_W'(qwl[QWL_W-1:Q_SPLIT]) * PP_W'(nsq5[N_SPLIT-1:0]);
      pp11 <= PP_W'(qwl[QWL_W-1:Q_SPLIT]) * PP_W'(nsq5[NSQ_W-1:N_SPLIT]);
      for (int i = 0; i < 3; i++) ssq6[i] <= SSQ_W'(smag5[i]) * SSQ_W'(smag5[i]);
      smag6 <= smag5;
      zero6 <= zero5;
      neg6  <= neg5;

      // Stage 7
      lo7   <= HALF_W'(pp00) + (HALF_W'(pp10) << Q_SPLIT);
      hi7   <= HALF_W'(pp01) + (HALF_W'(pp11) << Q_SPLIT);
      ssum7 <= SSUM_W'(ssq6[0]) + SSUM_W'(ssq6[1]) + SSUM_W'(ssq6[2]);
      smag7 <= smag6;
      zero7 <= zero6;
      neg7  <= neg6;

      // Stage 8: full product plus the rounding half.
      prod8 <= S2P_W'(lo7) + (S2P_W'(hi7) << N_SPLIT) + (S2P_W'(1) << S2_ROUND);
      ssum8 <= ssum7;
      smag8 <= smag7;
      zero8 <= zero7;
      neg8  <= neg7;
    end
  end

  assign sat8 = |prod8[S2P_W-1:S2_LSB+OUT_W];

  assign out_valid            = vld[7];
  assign out_ssum             = ssum8;
  assign out_pay.smag         = smag8;
  assign out_pay.side.neg     = neg8;
  assign out_pay.side.zero    = zero8;
  assign out_pay.side.sat     = sat8;
  assign out_pay.side.sin_sq  = sat8 ? {OUT_W{1'b1}} : prod8[S2_LSB +: OUT_W];

endmodule

`default_nettype wire

// ----- src/brn_isqrt.sv -----
// ----------------------------------------------------------------------------
// Bragg reflector normal: pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage over 32
// stages. The item's payload travels alongside, stage for stage.
// ----------------------------------------------------------------------------
`default_nettype none

module brn_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [brn_pkg::SSUM_W-1:0] in_rad,
  input  brn_pkg::sqrt_pay_t         in_pay,
  output logic                       out_valid,
  output logic [brn_pkg::ROOT_W-1:0] out_root,
  output brn_pkg::sqrt_pay_t         out_pay
);
  import brn_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [ROOT_W-1:0] vld;

  // Registers after each step.
  logic [REM_W-1:0]  r_rem  [ROOT_W];
  logic [ROOT_W-1:0] r_root [ROOT_W];
  logic [SSUM_W-1:0] r_rad  [ROOT_W];
  sqrt_pay_t         r_pay  [ROOT_W];

  // Inputs of each step and the values it produces.
  logic [REM_W-1:0]  st_rem  [ROOT_W];
  logic [ROOT_W-1:0] st_root [ROOT_W];
  logic [SSUM_W-1:0] st_rad  [ROOT_W];
  logic [REM_W-1:0]  nx_rem  [ROOT_W];
  logic [ROOT_W-1:0] nx_root [ROOT_W];

  always_comb begin
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    st_rem[0]  = '0;
    st_root[0] = '0;
    st_rad[0]  = in_rad;
    for (int k = 1; k < ROOT_W; k++) begin
      st_rem[k]  = r_rem[k-1];
      st_root[k] = r_root[k-1];
      st_rad[k]  = r_rad[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      // Bring down the next two radicand bits and try root*4+1.
      cur   = {st_rem[k][REM_W-3:0], st_rad[k][SSUM_W-1 -: 2]};
      trial = REM_W'({st_root[k], 2'b01});
      if (cur >= trial) begin
        nx_rem[k]  = cur - trial;
        nx_root[k] = {st_root[k][ROOT_W-2:0], 1'b1};
      end else begin
        nx_rem[k]  = cur;
        nx_root[k] = {st_root[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ROOT_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_pay[0] <= in_pay;
      for (int k = 1; k < ROOT_W; k++) r_pay[k] <= r_pay[k-1];
      for (int k = 0; k < ROOT_W; k++) begin
        r_rem[k]  <= nx_rem[k];
        r_root[k] <= nx_root[k];
        r_rad[k]  <= st_rad[k] << 2;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = r_root[ROOT_W-1];
  assign out_pay   = r_pay[ROOT_W-1];

endmodule

`default_nettype wire

// ----- src/brn_divide.sv -----
// ----------------------------------------------------------------------------
// Bragg reflector normal: pipelined divider
// Three lanes of rounded division of a normalized magnitude by the length.
// One setup stage forms the rounded numerator, then one quotient bit per
// stage over FRAC_BITS + 1 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module brn_divide #(
  parameter int FRAC_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [brn_pkg::ROOT_W-1:0] in_len,
  input  brn_pkg::sqrt_pay_t         in_pay,
  output logic                       out_valid,
  output logic [2:0][FRAC_BITS:0]    out_q,
  output brn_pkg::side_t             out_side
);
  import brn_pkg::*;

  localparam int QW    = FRAC_BITS + 1;
  localparam int NUM_W = SMAG_W + FRAC_BITS + 1;

  logic [QW:0] vld;

  // Setup stage registers.
  logic [ROOT_W-1:0] s_rem [3];
  logic [QW-1:0]     s_dq  [3];
  logic [ROOT_W-1:0] s_len;
  side_t             s_side;

  // Step registers. The dq word shifts numerator bits out at the top and
  // quotient bits in at the bottom.
  logic [ROOT_W-1:0] r_rem [QW][3];
  logic [QW-1:0]     r_dq  [QW][3];
  logic [ROOT_W-1:0] r_len [QW];
  side_t             r_side [QW];

  logic [ROOT_W-1:0] st_rem [QW][3];
  logic [QW-1:0]     st_dq  [QW][3];
  logic [ROOT_W-1:0] st_len [QW];
  logic [ROOT_W-1:0] nx_rem [QW][3];
  logic [QW-1:0]     nx_dq  [QW][3];

  always_comb begin
    logic [ROOT_W:0] cur;
    logic            ge;
    for (int i = 0; i < 3; i++) begin
      st_rem[0][i] = s_rem[i];
      st_dq[0][i]  = s_dq[i];
    end
    st_len[0] = s_len;
    for (int k = 1; k < QW; k++) begin
      for (int i = 0; i < 3; i++) begin
        st_rem[k][i] = r_rem[k-1][i];
        st_dq[k][i]  = r_dq[k-1][i];
      end
      st_len[k] = r_len[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      for (int i = 0; i < 3; i++) begin
        cur = {st_rem[k][i], st_dq[k][i][QW-1]};
        ge  = (cur >= {1'b0, st_len[k]});
        nx_rem[k][i] = ge ? ROOT_W'(cur - {1'b0, st_len[k]}) : cur[ROOT_W-1:0];
        nx_dq[k][i]  = {st_dq[k][i][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] num;
    if (adv) begin
      // The quotient stays below 2^QW, so the bits above QW start the remainder.
      for (int i = 0; i < 3; i++) begin
        num = (NUM_W'(in_pay.smag[i]) << FRAC_BITS) + NUM_W'(in_len >> 1);
        s_rem[i] <= ROOT_W'(num >> QW);
        s_dq[i]  <= num[QW-1:0];
      end
      s_len  <= in_len;
      s_side <= in_pay.side;

      r_side[0] <= s_side;
      for (int k = 1; k < QW; k++) r_side[k] <= r_side[k-1];
      for (int k = 0; k < QW; k++) begin
        for (int i = 0; i < 3; i++) begin
          r_rem[k][i] <= nx_rem[k][i];
          r_dq[k][i]  <= nx_dq[k][i];
        end
        r_len[k] <= st_len[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_side  = r_side[QW-1];
  assign out_q[0]  = r_dq[QW-1][0];
  assign out_q[1]  = r_dq[QW-1][1];
  assign out_q[2]  = r_dq[QW-1][2];

endmodule

`default_nettype wire

// ----- src/bragg_reflector_normal.sv -----
// ----------------------------------------------------------------------------
// Bragg reflector normal
// Maps Miller indices through a loaded 3x3 matrix and returns the unit
// normal of the result and sin^2 of the Bragg angle, in fixed point.
//
// Usage:
// - Load the three matrix rows (indexes 0..2) and lambda^2/4 (index 3) on
//   the write port while no item is in flight.
// - Input items arrive on s_axis: h, k and l in tdata, one reflector each.
// - Each input item gives exactly one result item on m_axis: the normal
//   components, sin^2 theta and an error code.
// - Throughput is one item per cycle while the skid register is free. From
//   acceptance to the result showing on m_axis an item passes eight front
//   stages, 32 square root stages, NORMAL_FRAC_BITS + 2 divider stages and
//   the output register.
// - When the receiver stalls, the output register holds its item and a
//   one-item skid register catches the next; s_axis_tready drops only once
//   the skid register is full, and the whole pipeline then holds in place.
// - Reset clears all valid bits, the skid register and the four
//   configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bragg_reflector_normal #(
  parameter int INDEX_LIMIT      = 63,
  parameter int NORMAL_FRAC_BITS = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // index_h [6:0], index_k [13:7], index_l [20:14], zero fill [23:21]
  input  logic [brn_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // normal_x [15:0], normal_y [31:16], normal_z [47:32], sin_sq_theta [63:48],
  // error_code [65:64], zero fill [71:66]
  output logic [brn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [brn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import brn_pkg::*;

  localparam int QW = NORMAL_FRAC_BITS + 1;
  localparam int CW = (QW > OUT_W + 1) ? QW : OUT_W + 1;

  logic [ROW_W-1:0] row_x, row_y, row_z;
  logic [QWL_W-1:0] qwl;

  logic                 adv;
  logic                 fr_valid;
  logic [SSUM_W-1:0]    fr_ssum;
  sqrt_pay_t            fr_pay;
  logic                 sq_valid;
  logic [ROOT_W-1:0]    sq_root;
  sqrt_pay_t            sq_pay;
  logic                 dv_valid;
  logic [2:0][QW-1:0]   dv_q;
  side_t                dv_side;

  logic [OUT_W-1:0]      nrm [3];
  err_t                  err;
  logic [OUT_DATA_W-1:0] res;

  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= '0;
      row_y <= '0;
      row_z <= '0;
      qwl   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_X: row_x <= cfg_data;
        REG_ROW_Y: row_y <= cfg_data;
        REG_ROW_Z: row_z <= cfg_data;
        REG_QWL:   qwl   <= cfg_data[QWL_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the skid register is free.
  assign adv           = !skid_valid;
  assign s_axis_tready = adv;

  brn_front #(
    .INDEX_LIMIT(INDEX_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_axis_tvalid),
    .in_h     (s_axis_tdata[IDX_W-1:0]),
    .in_k     (s_axis_tdata[2*IDX_W-1:IDX_W]),
    .in_l     (s_axis_tdata[3*IDX_W-1:2*IDX_W]),
    .row_x    (row_x),
    .row_y    (row_y),
    .row_z    (row_z),
    .qwl      (qwl),
    .out_valid(fr_valid),
    .out_ssum (fr_ssum),
    .out_pay  (fr_pay)
  );

  brn_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (fr_valid),
    .in_rad   (fr_ssum),
    .in_pay   (fr_pay),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_pay  (sq_pay)
  );

  brn_divide #(
    .FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_divide (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (sq_valid),
    .in_len   (sq_root),
    .in_pay   (sq_pay),
    .out_valid(dv_valid),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // Clamp the quotients and apply the signs.
  always_comb begin
    logic [CW-1:0] qe;
    logic [CW-1:0] lim;
    for (int i = 0; i < 3; i++) begin
      qe  = CW'(dv_q[i]);
      lim = dv_side.neg[i] ? (CW'(1) << NORMAL_FRAC_BITS)
                           : (CW'(1) << NORMAL_FRAC_BITS) - CW'(1);
      if (qe > lim) qe = lim;
      if (dv_side.neg[i]) begin
        if (qe > CW'(OUT_NEG_MAX)) qe = CW'(OUT_NEG_MAX);
        nrm[i] = -OUT_W'(qe);
      end else begin
        if (qe > CW'(OUT_POS_MAX)) qe = CW'(OUT_POS_MAX);
        nrm[i] = OUT_W'(qe);
      end
    end
    if (dv_side.zero) begin
      err = ERR_ZERO;
      res = {{(OUT_DATA_W - 4*OUT_W - ERR_W){1'b0}}, err, {(4*OUT_W){1'b0}}};
    end else begin
      err = dv_side.sat ? ERR_SAT : ERR_OK;
      res = {{(OUT_DATA_W - 4*OUT_W - ERR_W){1'b0}}, err, dv_side.sin_sq,
             nrm[2], nrm[1], nrm[0]};
    end
  end

  // Output register with a one-item skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) skid_valid <= 1'b0;
    end else if (dv_valid) begin
      if (!out_valid || m_axis_tready) out_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) out_data <= skid_data;
    end else if (dv_valid) begin
      if (!out_valid || m_axis_tready) out_data <= res;
      else skid_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

// ----- src/brn_checker.sv -----
// ----------------------------------------------------------------------------
// Bragg reflector normal: port checker
// Watches the top level's stream ports and checks the result encoding and
// the link between input backpressure and a waiting result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bragg_reflector_normal_defines.svh"

module brn_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [brn_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import brn_pkg::*;

  localparam int ERR_LSB = 4 * OUT_W;

  logic [ERR_W-1:0] code;
  logic [OUT_W-1:0] sin_sq;

  assign code   = m_axis_tdata[ERR_LSB +: ERR_W];
  assign sin_sq = m_axis_tdata[3*OUT_W +: OUT_W];

  // A stalled result holds.
  `BRN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Only the three defined error codes appear.
  `BRN_ASSERT_IMPL(a_code_known, m_axis_tvalid, code == ERR_OK || code == ERR_ZERO || code == ERR_SAT)

  // A zero vector clears every other field.
  `BRN_ASSERT_IMPL(a_zero_clears, m_axis_tvalid && code == ERR_ZERO, m_axis_tdata[ERR_LSB-1:0] == '0)

  // Saturation shows the largest sine squared.
  `BRN_ASSERT_IMPL(a_sat_full, m_axis_tvalid && code == ERR_SAT, sin_sq == {OUT_W{1'b1}})

  // The input side only stalls while a result is waiting.
  `BRN_ASSERT_IMPL(a_stall_has_result, !s_axis_tready, m_axis_tvalid)

endmodule

bind bragg_reflector_normal brn_checker u_brn_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

// ----- test/bragg_reflector_normal_tb.sv -----
// ----------------------------------------------------------------------------
// Bragg reflector normal: testbench
// Streams Miller index items through the block under several matrix and
// wavelength settings. Each result item is compared, field by field, with a
// prediction of the unit normal, sin^2 theta and the error code. The run
// includes random idling on both sides, a long receiver hold-off and full
// drains between settings.
// ----------------------------------------------------------------------------
module bragg_reflector_normal_tb;
  import brn_pkg::*;

  localparam int INDEX_LIMIT      = 63;
  localparam int NORMAL_FRAC_BITS = 15;
  localparam int LATENCY          = NORMAL_FRAC_BITS + 43;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int MAX_REPORTS      = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [OUT_W-1:0] normal_x;
    logic [OUT_W-1:0] normal_y;
    logic [OUT_W-1:0] normal_z;
    logic [OUT_W-1:0] sin_sq;
    err_t             err;
  } reflection_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we        = 1'b0;
  cfg_reg_t              cfg_index     = REG_ROW_X;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // Copy of the configuration registers as the block should hold them.
  logic [ROW_W-1:0] row_x  = '0;
  logic [ROW_W-1:0] row_y  = '0;
  logic [ROW_W-1:0] row_z  = '0;
  logic [QWL_W-1:0] qwl_sq = '0;

  reflection_t awaited_reflections[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_len       = 0;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int fail_count     = 0;
  int report_count   = 0;
  int cycle_count    = 0;

  bragg_reflector_normal #(
    .INDEX_LIMIT      (INDEX_LIMIT),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // index_h [6:0], index_k [13:7], index_l [20:14], zero fill [23:21]
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // normal_x [15:0], normal_y [31:16], normal_z [47:32], sin_sq_theta [63:48],
    // error_code [65:64], zero fill [71:66]
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Works out the normal, sin^2 theta and error code for one index item.
  function automatic reflection_t predict_reflection(input logic [IN_DATA_W-1:0] word);
    logic [ROW_W-1:0] rows [3];
    longint           idx [3];
    longint           g;
    logic [63:0]      mag [3];
    logic             neg [3];
    logic [63:0]      nsq;
    logic [63:0]      big;
    logic [63:0]      ssum;
    logic [63:0]      len;
    logic [63:0]      cand;
    logic [63:0]      q;
    logic [63:0]      lim;
    logic [127:0]     prod;
    logic [OUT_W-1:0] nrm [3];
    int               top;
    reflection_t      r;
    rows[0] = row_x;
    rows[1] = row_y;
    rows[2] = row_z;
    nsq  = '0;
    big  = '0;
    ssum = '0;
    top  = 0;
    for (int j = 0; j < 3; j++) begin
      idx[j] = longint'($signed(word[IDX_W*j +: IDX_W]));
      if (idx[j] > INDEX_LIMIT) idx[j] = INDEX_LIMIT;
      if (idx[j] < -INDEX_LIMIT) idx[j] = -INDEX_LIMIT;
    end
    for (int i = 0; i < 3; i++) begin
      g = 0;
      for (int j = 0; j < 3; j++) begin
        g += longint'($signed(rows[i][ENTRY_W*j +: ENTRY_W])) * idx[j];
      end
      neg[i] = (g < 0);
      mag[i] = neg[i] ? 64'(-g) : 64'(g);
      nsq += (mag[i] * mag[i]) >> 2;
      if (mag[i] > big) big = mag[i];
    end
    if (big == 0) begin
      r = '{normal_x: '0, normal_y: '0, normal_z: '0, sin_sq: '0, err: ERR_ZERO};
      return r;
    end

    // Rounded (lambda^2/4 * |g|^2) >> 56, saturated to 16 bits.
    prod = 128'(qwl_sq) * 128'(nsq);
    prod = (prod + (128'd1 << 55)) >> 56;
    if (prod > 128'd65535) begin
      r.sin_sq = 16'hFFFF;
      r.err    = ERR_SAT;
    end else begin
      r.sin_sq = prod[OUT_W-1:0];
      r.err    = ERR_OK;
    end

    // Bring the largest component to bit 30 before taking the length.
    for (int b = 0; b < 64; b++) begin
      if (big[b]) top = b;
    end
    for (int i = 0; i < 3; i++) begin
      if (top < NORM_TOP) mag[i] = mag[i] << (NORM_TOP - top);
      else if (top > NORM_TOP) mag[i] = mag[i] >> (top - NORM_TOP);
      ssum += mag[i] * mag[i];
    end
    len = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = len | (64'd1 << b);
      if (cand * cand <= ssum) len = cand;
    end

    for (int i = 0; i < 3; i++) begin
      q   = ((mag[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
      lim = (64'd1 << NORMAL_FRAC_BITS) - (neg[i] ? 64'd0 : 64'd1);
      if (q > lim) q = lim;
      if (neg[i]) begin
        if (q > 64'(OUT_NEG_MAX)) q = 64'(OUT_NEG_MAX);
        nrm[i] = ~q[OUT_W-1:0] + 16'd1;
      end else begin
        if (q > 64'(OUT_POS_MAX)) q = 64'(OUT_POS_MAX);
        nrm[i] = q[OUT_W-1:0];
      end
    end
    r.normal_x = nrm[0];
    r.normal_y = nrm[1];
    r.normal_z = nrm[2];
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(input logic [ENTRY_W-1:0] eh,
                                                input logic [ENTRY_W-1:0] ek,
                                                input logic [ENTRY_W-1:0] el);
    return {el, ek, eh};
  endfunction

  // Mostly full-range indices, with zeros and small values mixed in.
  function automatic logic [IDX_W-1:0] random_index();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return IDX_W'($urandom_range(6) - 3);
      default: return IDX_W'($urandom);
    endcase
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER)   ? 84 : (mode == IDLE_BOTH) ? 31 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 84 : (mode == IDLE_BOTH) ? 31 : 0;
  endtask

  // Offers one item and returns at the edge where it is accepted.
  task automatic send_reflector(input logic [IDX_W-1:0] h, input logic [IDX_W-1:0] k,
                                input logic [IDX_W-1:0] l);
    logic [IN_DATA_W-1:0] word;
    reflection_t          predicted;
    word = {3'b000, l, k, h};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = predict_reflection(word);
    awaited_reflections.insert(awaited_reflections.size(), predicted);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_reflections.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      REG_ROW_X: row_x  = value;
      REG_ROW_Y: row_y  = value;
      REG_ROW_Z: row_z  = value;
      REG_QWL:   qwl_sq = value[QWL_W-1:0];
    endcase
  endtask

  task automatic load_setting(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                              input logic [ROW_W-1:0] rz,
                              input logic [CFG_DATA_W-1:0] qwl_data);
    wait_drained();
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
    write_reg(REG_QWL, qwl_data);
  endtask

  // With the registers still at reset every vector maps to zero.
  task automatic test_reset_defaults();
    set_idle(IDLE_NONE);
    send_reflector(7'd1, 7'd2, 7'd3);
    send_reflector(7'h40, 7'h3F, 7'h7F);
    send_reflector(7'd0, 7'd0, 7'd0);
  endtask

  // Identity matrix: axis vectors hit the normal clamps, big ones saturate.
  task automatic test_unit_axes();
    logic [ENTRY_W-1:0] one;
    one = 21'd131072;
    load_setting(pack_row(one, '0, '0), pack_row('0, one, '0), pack_row('0, '0, one),
                 CFG_DATA_W'(40'd1 << 28));
    set_idle(IDLE_BOTH);
    send_reflector(7'd1, 7'd0, 7'd0);
    send_reflector(7'h7F, 7'd0, 7'd0);
    send_reflector(7'd0, 7'd63, 7'd0);
    send_reflector(7'd0, 7'd0, 7'h40);
    send_reflector(7'd63, 7'd63, 7'd63);
    send_reflector(7'h40, 7'h40, 7'h40);
    send_reflector(7'd0, 7'd0, 7'd0);
    send_reflector(7'd8, 7'd8, 7'd8);
    send_reflector(7'd3, 7'h7E, 7'd5);
  endtask

  // Largest positive entries and the largest wavelength term.
  task automatic test_saturation_extremes();
    logic [ROW_W-1:0] r;
    r = pack_row(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF);
    load_setting(r, r, r, CFG_DATA_W'(40'hFF_FFFF_FFFF));
    set_idle(IDLE_RECEIVER);
    send_reflector(7'd63, 7'd63, 7'd63);
    send_reflector(7'd1, 7'd0, 7'd0);
    send_reflector(7'h40, 7'd0, 7'd1);
  endtask

  // Most negative entries, a tiny wavelength term written with junk above
  // the register width, and index sums that leave small vectors.
  task automatic test_negative_extremes();
    logic [ROW_W-1:0] r;
    r = pack_row(21'h100000, 21'h100000, 21'h100000);
    load_setting(r, r, r, {23'h7FFFFF, 40'd1});
    set_idle(IDLE_SENDER);
    send_reflector(7'd63, 7'h40, 7'd1);
    send_reflector(7'd1, 7'd1, 7'd1);
    send_reflector(7'h7B, 7'd0, 7'd0);
    send_reflector(7'h40, 7'd0, 7'd0);
  endtask

  // Only the h column is nonzero, so items with h = 0 map to the zero vector.
  task automatic test_singular_matrix();
    load_setting(pack_row(21'd131072, '0, '0), pack_row(21'h1E0000, '0, '0),
                 pack_row(21'd5, '0, '0), CFG_DATA_W'(40'd1 << 30));
    set_idle(IDLE_NONE);
    send_reflector(7'd0, 7'd5, 7'h79);
    send_reflector(7'd2, 7'd5, 7'h79);
    send_reflector(7'd0, 7'h40, 7'd63);
    send_reflector(7'h7F, 7'd0, 7'd0);
  endtask

  task automatic test_random_settings();
    logic [ROW_W-1:0]          rows [3];
    logic signed [ENTRY_W-1:0] e;
    logic [QWL_W-1:0]          q;
    logic [CFG_DATA_W-1:0]     d;
    for (int p = 0; p < 8; p++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          case ($urandom_range(3))
            0: e = ENTRY_W'($urandom);
            1: begin
              e = ENTRY_W'($urandom);
              e = e >>> $urandom_range(ENTRY_W - 1);
            end
            2: e = '0;
            default: e = $urandom_range(1) ? 21'sd131072 : -21'sd131072;
          endcase
          rows[i][ENTRY_W*j +: ENTRY_W] = e;
        end
      end
      q = QWL_W'({$urandom, $urandom});
      q = q >> $urandom_range(QWL_W - 1);
      d = CFG_DATA_W'({$urandom, $urandom});
      d[QWL_W-1:0] = q;
      load_setting(rows[0], rows[1], rows[2], d);
      set_idle(idle_mode_t'(p % 4));
      repeat (90) send_reflector(random_index(), random_index(), random_index());
    end
  endtask

  // The receiver holds off long enough for the pipeline and skid register to
  // fill, so the input side has to stall; later the sender pauses mid-stream
  // until everything has come out.
  task automatic test_backpressure();
    set_idle(IDLE_NONE);
    hold_len = 4 * LATENCY;
    hold_seq = hold_seq + 1;
    repeat (150) send_reflector(random_index(), random_index(), random_index());
    wait_drained();
    set_idle(IDLE_BOTH);
    repeat (40) send_reflector(random_index(), random_index(), random_index());
    wait_drained();
    repeat (40) send_reflector(random_index(), random_index(), random_index());
  endtask

  // Result checking.
  always @(posedge clk) begin
    reflection_t      exp;
    logic [OUT_W-1:0] got_x;
    logic [OUT_W-1:0] got_y;
    logic [OUT_W-1:0] got_z;
    logic [OUT_W-1:0] got_s2;
    logic [ERR_W-1:0] got_err;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_x   = m_axis_tdata[15:0];
      got_y   = m_axis_tdata[31:16];
      got_z   = m_axis_tdata[47:32];
      got_s2  = m_axis_tdata[63:48];
      got_err = m_axis_tdata[65:64];
      if (awaited_reflections.size() == 0) begin
        fail_count++;
        if (report_count < MAX_REPORTS) begin
          $display("unexpected result item: %h", m_axis_tdata);
        end
        report_count++;
      end else begin
        exp = awaited_reflections.pop_front();
        if (got_x !== exp.normal_x || got_y !== exp.normal_y || got_z !== exp.normal_z ||
            got_s2 !== exp.sin_sq || got_err !== exp.err) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            $display("mismatch: expected n=(%0d,%0d,%0d) s2=%0d err=%0d",
                     $signed(exp.normal_x), $signed(exp.normal_y), $signed(exp.normal_z),
                     exp.sin_sq, exp.err);
            $display("          got      n=(%0d,%0d,%0d) s2=%0d err=%0d",
                     $signed(got_x), $signed(got_y), $signed(got_z), got_s2, got_err);
          end
          report_count++;
        end
      end
    end
  end

  // Receiver: a long hold-off when one is requested, random stalls otherwise.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_unit_axes();
    test_saturation_extremes();
    test_negative_extremes();
    test_singular_matrix();
    test_random_settings();
    test_backpressure();
    wait_drained();
    repeat (LATENCY + 12) @(posedge clk);
    if (fail_count == 0 && awaited_reflections.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
